// ===== rtl/core/mts_pkg.sv =====
// Shared constants and types for the min-tracking stack.
`timescale 1ns / 1ps
package mts_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

endpackage

// ===== rtl/core/mts_ram.sv =====
// Simple dual-port synchronous RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module mts_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/min_tracking_stack.sv =====
// Top level: signed stack with minimum tracking, built on two RAMs.
//
// Usage:
//   Command channel: present kind (0 push, 1 pop) and value with start high;
//   the beat is taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle; top_value,
//   min_value, is_empty and overflow are valid in that cycle only. The
//   receiver cannot stall, so results are never held back.
//   Sequencing: a push, a pop of an empty stack, or a dropped push gives its
//   result in the cycle after acceptance and the next command may follow at
//   once (1 item per cycle). A pop of a non-empty stack reads the new top
//   from the element and minimum RAMs, whose read port is registered; busy is
//   high for a single cycle while the read data is taken, the result is then
//   registered, and no new command is taken until the pop has completed.
//   The top element and current minimum are kept in registers beside the
//   RAMs; the RAMs also hold them at the top entries.
//   Reset: counts clear, minimum returns to -1, the stack is empty. The
//   RAMs are not cleared; only entries below the counts are ever used.
`timescale 1ns / 1ps
module min_tracking_stack (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                kind,
    input  logic signed [mts_pkg::DATA_W-1:0]   value,
    output logic                                done,
    output logic signed [mts_pkg::DATA_W-1:0]   top_value,
    output logic signed [mts_pkg::DATA_W-1:0]   min_value,
    output logic                                is_empty,
    output logic                                overflow
);
    import mts_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         elem_cnt_reg, elem_cnt_next;
    logic [CNT_W-1:0]         min_cnt_reg, min_cnt_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic                     hit_reg, hit_next;
    logic                     done_reg, done_next;
    logic signed [DATA_W-1:0] res_top_reg, res_top_next;
    logic signed [DATA_W-1:0] res_min_reg, res_min_next;
    logic                     res_empty_reg, res_empty_next;
    logic                     res_ovf_reg, res_ovf_next;

    logic                     accept;
    logic                     elem_we, min_we;
    logic [ADDR_W-1:0]        elem_waddr, min_waddr;
    logic [ADDR_W-1:0]        elem_raddr, min_raddr;
    logic [DATA_W-1:0]        elem_rdata, min_rdata;
    logic [CNT_W-1:0]         elem_rd_cnt, min_rd_cnt;
    logic [CNT_W-1:0]         min_cnt_dec;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg == ST_POP);

    assign elem_rd_cnt = elem_cnt_reg - TWO_CNT;
    assign min_rd_cnt  = min_cnt_reg - TWO_CNT;
    assign elem_raddr  = elem_rd_cnt[ADDR_W-1:0];
    assign min_raddr   = min_rd_cnt[ADDR_W-1:0];
    assign elem_waddr  = elem_cnt_reg[ADDR_W-1:0];
    assign min_waddr   = min_cnt_reg[ADDR_W-1:0];
    assign min_cnt_dec = (min_cnt_reg != '0) ? (min_cnt_reg - ONE_CNT) : '0;

    mts_ram #(.DATA_W(DATA_W), .ADDR_W(ADDR_W)) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (value),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    mts_ram #(.DATA_W(DATA_W), .ADDR_W(ADDR_W)) u_min_ram (
        .clk   (clk),
        .we    (min_we),
        .waddr (min_waddr),
        .wdata (value),
        .raddr (min_raddr),
        .rdata (min_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            elem_cnt_reg <= '0;
            min_cnt_reg  <= '0;
            min_reg      <= ALL_ONES;
            top_reg      <= ALL_ONES;
            hit_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            elem_cnt_reg <= elem_cnt_next;
            min_cnt_reg  <= min_cnt_next;
            min_reg      <= min_next;
            top_reg      <= top_next;
            hit_reg      <= hit_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_top_reg   <= res_top_next;
        res_min_reg   <= res_min_next;
        res_empty_reg <= res_empty_next;
        res_ovf_reg   <= res_ovf_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        elem_cnt_next  = elem_cnt_reg;
        min_cnt_next   = min_cnt_reg;
        top_next       = top_reg;
        min_next       = min_reg;
        hit_next       = hit_reg;
        done_next      = 1'b0;
        elem_we        = 1'b0;
        min_we         = 1'b0;
        res_top_next   = res_top_reg;
        res_min_next   = res_min_reg;
        res_empty_next = res_empty_reg;
        res_ovf_next   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_PUSH)
                    begin
                        done_next = 1'b1;
                        if (elem_cnt_reg >= FULL_CNT)
                        begin
                            // full: drop, report unchanged stack
                            res_ovf_next   = 1'b1;
                            res_top_next   = top_reg;
                            res_min_next   = min_reg;
                            res_empty_next = 1'b0;
                        end
                        else
                        begin
                            elem_we       = 1'b1;
                            top_next      = value;
                            elem_cnt_next = elem_cnt_reg + ONE_CNT;
                            if ((elem_cnt_reg == '0) || (value <= min_reg))
                            begin
                                min_next = value;
                                if (min_cnt_reg < FULL_CNT)
                                begin
                                    min_we       = 1'b1;
                                    min_cnt_next = min_cnt_reg + ONE_CNT;
                                end
                            end
                            res_top_next   = value;
                            res_min_next   = min_next;
                            res_empty_next = 1'b0;
                        end
                    end
                    else if (elem_cnt_reg == '0)
                    begin
                        done_next      = 1'b1;
                        res_top_next   = ALL_ONES;
                        res_min_next   = ALL_ONES;
                        res_empty_next = 1'b1;
                    end
                    else
                    begin
                        // RAM reads of the new tops are in flight
                        hit_next   = (top_reg == min_reg);
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP:
            begin
                done_next     = 1'b1;
                state_next    = ST_IDLE;
                elem_cnt_next = elem_cnt_reg - ONE_CNT;
                top_next      = (elem_cnt_reg == ONE_CNT) ? ALL_ONES : elem_rdata;
                if (hit_reg)
                begin
                    min_cnt_next = min_cnt_dec;
                    min_next     = (min_cnt_dec != '0) ? min_rdata : ALL_ONES;
                end
                if (elem_cnt_reg == ONE_CNT)
                begin
                    res_top_next   = ALL_ONES;
                    res_min_next   = ALL_ONES;
                    res_empty_next = 1'b1;
                end
                else
                begin
                    res_top_next   = top_next;
                    res_min_next   = min_next;
                    res_empty_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done      = done_reg;
    assign top_value = res_top_reg;
    assign min_value = res_min_reg;
    assign is_empty  = res_empty_reg;
    assign overflow  = res_ovf_reg;

`ifndef SYNTHESIS
    a_pop_completes: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("pop did not complete after one busy cycle");

    a_empty_reports_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_empty) |-> ((top_value == ALL_ONES) && (min_value == ALL_ONES)))
        else $error("empty result without -1 fields");

    a_overflow_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow |-> (done && !is_empty && (elem_cnt_reg == FULL_CNT)))
        else $error("overflow reported on a stack that is not full");

    a_pop_enters_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_POP) && (elem_cnt_reg != '0)) |=> busy)
        else $error("non-empty pop did not enter the read cycle");

    a_min_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (min_cnt_reg <= elem_cnt_reg))
        else $error("minimum count exceeds element count");
`endif

endmodule
